[rtl/core/ipv4hc_pkg.sv]
// ipv4hc_pkg: shared types and constants for the ipv4 receive header check
// used by ipv4_receive_header_check and its checker; no dependencies
`default_nettype none

package ipv4hc_pkg;

    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 64;
    localparam int unsigned PADDR_W     = 3;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT      = 17'h10000;
    localparam logic [COUNT_W-1:0] MIN_HEADER_BYTES = 17'd20;
    localparam logic [5:0]         MIN_HEADER_6     = 6'd20;
    localparam logic [15:0]        SUM_GOOD         = 16'hFFFF;
    localparam logic [31:0]        BROADCAST_ADDR   = 32'hFFFFFFFF;
    localparam logic [31:0]        ZERO_ADDR        = 32'h00000000;
    localparam logic [3:0]         IP_VERSION4      = 4'd4;
    localparam logic [3:0]         IHL_MASK         = 4'hF;

    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // register index carried in paddr[2]
    localparam logic REG_LOCAL_ADDRESS = 1'b0;

    // byte offsets in the header
    localparam logic [COUNT_W-1:0] OFS_VER_IHL   = 17'd0;
    localparam logic [COUNT_W-1:0] OFS_LEN_HI    = 17'd2;
    localparam logic [COUNT_W-1:0] OFS_LEN_LO    = 17'd3;
    localparam logic [COUNT_W-1:0] OFS_PROTOCOL  = 17'd9;
    localparam logic [COUNT_W-1:0] OFS_SRC_FIRST = 17'd12;
    localparam logic [COUNT_W-1:0] OFS_SRC_LAST  = 17'd15;
    localparam logic [COUNT_W-1:0] OFS_DST_FIRST = 17'd16;
    localparam logic [COUNT_W-1:0] OFS_DST_LAST  = 17'd19;

    typedef enum logic [2:0] {
        VERDICT_DELIVER   = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_VERSION   = 3'd2,
        VERDICT_IHL       = 3'd3,
        VERDICT_CHECKSUM  = 3'd4,
        VERDICT_TOTAL_LEN = 3'd5,
        VERDICT_NOT_OURS  = 3'd6,
        VERDICT_PROTOCOL  = 3'd7
    } verdict_t;

    typedef enum logic [1:0] {
        CLASS_UDP   = 2'd0,
        CLASS_TCP   = 2'd1,
        CLASS_ICMP  = 2'd2,
        CLASS_OTHER = 2'd3
    } proto_class_t;

    typedef struct packed {
        logic [15:0]  payload_bytes;
        logic [5:0]   header_bytes;
        logic [31:0]  source_address;
        proto_class_t protocol_class;
        verdict_t     verdict;
    } result_t;

    function automatic proto_class_t class_of(input logic [7:0] proto);
        proto_class_t c;
        case (proto)
            PROTO_UDP:  c = CLASS_UDP;
            PROTO_TCP:  c = CLASS_TCP;
            PROTO_ICMP: c = CLASS_ICMP;
            default:    c = CLASS_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ipv4_receive_header_check.sv]
// ipv4_receive_header_check: checks an ipv4 header streamed one byte per word
// and gives one verdict word per packet; uses ipv4hc_pkg
// a verdict word is registered in the result register when the last byte leaves the input register
// throughput: one byte per cycle while input is not stalled, set by the single input and result register pair
// a waiting verdict word stalls input only once the next last byte is in the input register
// reset: rst_n asynchronous active low clears packet state, local_address and the valid flags of both registers
`default_nettype none

module ipv4_receive_header_check
    import ipv4hc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic                   s_tlast,   // last_byte
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [2:0] verdict, [4:3] protocol_class, [36:5] source_address,
    // [42:37] header_bytes, [58:43] payload_bytes, [63:59] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0]        local_address_reg;
    logic [7:0]         in_data_reg;
    logic               in_last_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    result_t            out_result_reg;
    result_t            result_next;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         ver_ihl_reg, ver_ihl_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         pending_reg, pending_next;
    logic [15:0]        length_reg, length_next;
    logic [7:0]         protocol_reg, protocol_next;
    logic [31:0]        source_reg, source_next;
    logic [31:0]        dest_reg, dest_next;

    logic               advance;
    logic               step;
    logic [5:0]         hdr;
    logic [16:0]        raw_sum;
    logic               is_ours;
    proto_class_t       pclass;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOCAL_ADDRESS) ? local_address_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_address_reg <= 32'h0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_LOCAL_ADDRESS)
            local_address_reg <= pwdata;
    end

    // input register moves on unless it holds a last byte and the result slot is full and m_tready is low
    assign advance  = !in_last_reg || !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_last_reg  <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
            in_last_reg  <= s_tlast;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
    end

    // per byte field capture and checksum
    always_comb
    begin
        ver_ihl_next  = (byte_count_reg == OFS_VER_IHL) ? in_data_reg : ver_ihl_reg;
        hdr           = {ver_ihl_next[3:0] & IHL_MASK, 2'b00};
        sum_next      = sum_reg;
        pending_next  = pending_reg;
        raw_sum       = {1'b0, sum_reg} + {1'b0, pending_reg, in_data_reg};
        if (byte_count_reg < {11'd0, hdr})
        begin
            if (!byte_count_reg[0])
                pending_next = in_data_reg;
            else
                sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};
        end

        length_next   = length_reg;
        protocol_next = protocol_reg;
        source_next   = source_reg;
        dest_next     = dest_reg;
        if (byte_count_reg == OFS_LEN_HI)
            length_next = {in_data_reg, length_reg[7:0]};
        else if (byte_count_reg == OFS_LEN_LO)
            length_next = {length_reg[15:8], in_data_reg};
        else if (byte_count_reg == OFS_PROTOCOL)
            protocol_next = in_data_reg;
        else if (byte_count_reg >= OFS_SRC_FIRST && byte_count_reg <= OFS_SRC_LAST)
            source_next = {source_reg[23:0], in_data_reg};
        else if (byte_count_reg >= OFS_DST_FIRST && byte_count_reg <= OFS_DST_LAST)
            dest_next = {dest_reg[23:0], in_data_reg};

        byte_count_next = (byte_count_reg < COUNT_LIMIT) ? byte_count_reg + 17'd1
                                                          : byte_count_reg;
    end

    // verdict from the state including the final byte
    always_comb
    begin
        pclass  = class_of(protocol_next);
        is_ours = (dest_next == local_address_reg) || (dest_next == BROADCAST_ADDR)
                  || (local_address_reg == ZERO_ADDR);

        if (byte_count_next < MIN_HEADER_BYTES)
            result_next.verdict = VERDICT_SHORT;
        else if (ver_ihl_next[7:4] != IP_VERSION4)
            result_next.verdict = VERDICT_VERSION;
        else if (hdr < MIN_HEADER_6 || {11'd0, hdr} > byte_count_next)
            result_next.verdict = VERDICT_IHL;
        else if (sum_next != SUM_GOOD)
            result_next.verdict = VERDICT_CHECKSUM;
        else if ({1'b0, length_next} > byte_count_next || length_next < {10'd0, hdr})
            result_next.verdict = VERDICT_TOTAL_LEN;
        else if (!is_ours)
            result_next.verdict = VERDICT_NOT_OURS;
        else if (pclass == CLASS_OTHER)
            result_next.verdict = VERDICT_PROTOCOL;
        else
            result_next.verdict = VERDICT_DELIVER;

        result_next.protocol_class = pclass;
        result_next.source_address = source_next;
        result_next.header_bytes   = hdr;
        result_next.payload_bytes  = (length_next >= {10'd0, hdr})
                                     ? length_next - {10'd0, hdr} : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            ver_ihl_reg    <= '0;
            sum_reg        <= '0;
            pending_reg    <= '0;
            length_reg     <= '0;
            protocol_reg   <= '0;
            source_reg     <= '0;
            dest_reg       <= '0;
        end
        else if (step && in_last_reg)
        begin
            byte_count_reg <= '0;
            ver_ihl_reg    <= '0;
            sum_reg        <= '0;
            pending_reg    <= '0;
            length_reg     <= '0;
            protocol_reg   <= '0;
            source_reg     <= '0;
            dest_reg       <= '0;
        end
        else if (step)
        begin
            byte_count_reg <= byte_count_next;
            ver_ihl_reg    <= ver_ihl_next;
            sum_reg        <= sum_next;
            pending_reg    <= pending_next;
            length_reg     <= length_next;
            protocol_reg   <= protocol_next;
            source_reg     <= source_next;
            dest_reg       <= dest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
            out_result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_result_reg};

endmodule

`default_nettype wire

[rtl/core/ipv4hc_checker.sv]
// ipv4hc_checker: port level assertions for ipv4_receive_header_check
// bound to the top level below; uses ipv4hc_pkg
`default_nettype none

module ipv4hc_checker
    import ipv4hc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an empty result slot never stalls input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result slot");

    // a delivered packet has a full header and a known protocol
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == VERDICT_DELIVER |->
            m_tdata[42:37] >= MIN_HEADER_6 && m_tdata[4:3] != CLASS_OTHER)
        else $error("deliver verdict on malformed header");

    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:59] == 5'd0)
        else $error("nonzero padding in result word");

endmodule

bind ipv4_receive_header_check ipv4hc_checker u_ipv4hc_checker (.*);

`default_nettype wire
